### hdl/md5rr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5rr_pkg
// shared types, constants and round tables of the round-reduced md5 hash
// ----------------------------------------------------------------------------
package md5rr_pkg;

	// data path
	localparam int WORD_W     = 32;
	localparam int BYTE_W     = 8;
	localparam int BANK_WORDS = 16;
	localparam int BANKS      = 2;
	localparam int RAM_DEPTH  = BANKS * BANK_WORDS;
	localparam int RAM_AW     = $clog2(RAM_DEPTH);
	localparam int DIGEST_W   = 4 * WORD_W;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam int STEP_W = 7;
	localparam logic REG_STEP_COUNT = 1'b0;
	localparam logic [STEP_W-1:0] STEP_COUNT_RESET = 7'd64;
	localparam logic [STEP_W-1:0] MAX_STEPS        = 7'd64;
	localparam logic [5:0]        LAST_STEP_FULL   = 6'd63;

	// input kinds carried in tuser
	localparam logic ACT_ABSORB = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	// padding
	localparam logic [7:0] PAD_BYTE      = 8'h80;
	localparam logic [5:0] LAST_POS      = 6'h3F;
	localparam logic [5:0] PAD_SPLIT_POS = 6'd56;
	localparam logic [3:0] LAST_WORD     = 4'd15;
	localparam logic [3:0] LEN_LO_WORD   = 4'd14;
	localparam logic [3:0] LEN_HI_WORD   = 4'd15;

	// four chaining words, word a in the low bits
	typedef logic [3:0][WORD_W-1:0] chain_t;

	localparam chain_t CHAIN_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

	// commands from the message control to the compression core
	typedef struct packed {
		logic       start;
		logic       init;
		logic       bank;
		logic [5:0] last_step;
	} core_ctrl_t;

	// additive constant of step i
	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0:  k = 32'd3614090360;
			6'd1:  k = 32'd3905402710;
			6'd2:  k = 32'd606105819;
			6'd3:  k = 32'd3250441966;
			6'd4:  k = 32'd4118548399;
			6'd5:  k = 32'd1200080426;
			6'd6:  k = 32'd2821735955;
			6'd7:  k = 32'd4249261313;
			6'd8:  k = 32'd1770035416;
			6'd9:  k = 32'd2336552879;
			6'd10: k = 32'd4294925233;
			6'd11: k = 32'd2304563134;
			6'd12: k = 32'd1804603682;
			6'd13: k = 32'd4254626195;
			6'd14: k = 32'd2792965006;
			6'd15: k = 32'd1236535329;
			6'd16: k = 32'd4129170786;
			6'd17: k = 32'd3225465664;
			6'd18: k = 32'd643717713;
			6'd19: k = 32'd3921069994;
			6'd20: k = 32'd3593408605;
			6'd21: k = 32'd38016083;
			6'd22: k = 32'd3634488961;
			6'd23: k = 32'd3889429448;
			6'd24: k = 32'd568446438;
			6'd25: k = 32'd3275163606;
			6'd26: k = 32'd4107603335;
			6'd27: k = 32'd1163531501;
			6'd28: k = 32'd2850285829;
			6'd29: k = 32'd4243563512;
			6'd30: k = 32'd1735328473;
			6'd31: k = 32'd2368359562;
			6'd32: k = 32'd4294588738;
			6'd33: k = 32'd2272392833;
			6'd34: k = 32'd1839030562;
			6'd35: k = 32'd4259657740;
			6'd36: k = 32'd2763975236;
			6'd37: k = 32'd1272893353;
			6'd38: k = 32'd4139469664;
			6'd39: k = 32'd3200236656;
			6'd40: k = 32'd681279174;
			6'd41: k = 32'd3936430074;
			6'd42: k = 32'd3572445317;
			6'd43: k = 32'd76029189;
			6'd44: k = 32'd3654602809;
			6'd45: k = 32'd3873151461;
			6'd46: k = 32'd530742520;
			6'd47: k = 32'd3299628645;
			6'd48: k = 32'd4096336452;
			6'd49: k = 32'd1126891415;
			6'd50: k = 32'd2878612391;
			6'd51: k = 32'd4237533241;
			6'd52: k = 32'd1700485571;
			6'd53: k = 32'd2399980690;
			6'd54: k = 32'd4293915773;
			6'd55: k = 32'd2240044497;
			6'd56: k = 32'd1873313359;
			6'd57: k = 32'd4264355552;
			6'd58: k = 32'd2734768916;
			6'd59: k = 32'd1309151649;
			6'd60: k = 32'd4149444226;
			6'd61: k = 32'd3174756917;
			6'd62: k = 32'd718787259;
			6'd63: k = 32'd3951481745;
			default: k = '0;
		endcase
		return k;
	endfunction

	// rotate amount of step i
	function automatic logic [4:0] md5_rot(input logic [5:0] i);
		logic [4:0] s;
		unique case ({i[5:4], i[1:0]})
			4'h0: s = 5'd7;
			4'h1: s = 5'd12;
			4'h2: s = 5'd17;
			4'h3: s = 5'd22;
			4'h4: s = 5'd5;
			4'h5: s = 5'd9;
			4'h6: s = 5'd14;
			4'h7: s = 5'd20;
			4'h8: s = 5'd4;
			4'h9: s = 5'd11;
			4'hA: s = 5'd16;
			4'hB: s = 5'd23;
			4'hC: s = 5'd6;
			4'hD: s = 5'd10;
			4'hE: s = 5'd15;
			4'hF: s = 5'd21;
			default: s = '0;
		endcase
		return s;
	endfunction

	// message word used by step i
	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [7:0] p;
		unique case (i[5:4])
			2'd0: p = {4'd0, i[3:0]};
			2'd1: p = {4'd0, i[3:0]} * 8'd5 + 8'd1;
			2'd2: p = {4'd0, i[3:0]} * 8'd3 + 8'd5;
			2'd3: p = {4'd0, i[3:0]} * 8'd7;
			default: p = '0;
		endcase
		return p[3:0];
	endfunction

endpackage
`default_nettype wire

### hdl/md5rr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5rr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module md5rr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### hdl/md5rr_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5rr_core
// compression core: one md5 step per cycle over a message block in ram
// ----------------------------------------------------------------------------
module md5rr_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  md5rr_pkg::core_ctrl_t         ctrl,
	input  logic [md5rr_pkg::WORD_W-1:0]  ram_rdata,
	output logic [md5rr_pkg::RAM_AW-1:0]  ram_raddr,
	output logic                          busy,
	output md5rr_pkg::chain_t             chain
);

	import md5rr_pkg::*;

	typedef enum logic [2:0] {
		EN_IDLE = 3'b001,
		EN_RUN  = 3'b010,
		EN_ADD  = 3'b100
	} eng_state_t;

	eng_state_t        state_q;
	logic [5:0]        step_q;
	logic [5:0]        last_q;
	logic              bank_q;
	chain_t            chain_q;
	logic [WORD_W-1:0] v_q [4];

	logic [5:0]        step_nxt;
	logic [WORD_W-1:0] fx;
	logic [WORD_W-1:0] sum;
	logic [63:0]       rot_w;
	logic [WORD_W-1:0] step_new;
	logic [1:0]        n2;
	chain_t            sel;
	chain_t            chain_sum;

	assign step_nxt = step_q + 6'd1;
	assign busy     = (state_q != EN_IDLE);
	assign chain    = chain_q;

	// read one step ahead so the word is in the ram output register on time
	always_comb begin
		if (state_q == EN_RUN) begin
			ram_raddr = {bank_q, md5_g(step_nxt)};
		end else begin
			ram_raddr = {ctrl.bank, md5_g(6'd0)};
		end
	end

	// registers rotate so the word being updated always sits in v_q[0]
	always_comb begin
		unique case (step_q[5:4])
			2'd0: fx = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			2'd1: fx = (v_q[1] & v_q[3]) | (v_q[2] & ~v_q[3]);
			2'd2: fx = v_q[1] ^ v_q[2] ^ v_q[3];
			2'd3: fx = v_q[2] ^ (v_q[1] | ~v_q[3]);
			default: fx = '0;
		endcase
		sum      = v_q[0] + fx + ram_rdata + md5_k(step_q);
		rot_w    = {sum, sum} << md5_rot(step_q);
		step_new = v_q[1] + rot_w[63:32];
	end

	// undo the register rotation for the add-back
	assign n2 = last_q[1:0] + 2'd1;

	always_comb begin
		unique case (n2)
			2'd0: sel = {v_q[3], v_q[2], v_q[1], v_q[0]};
			2'd1: sel = {v_q[0], v_q[3], v_q[2], v_q[1]};
			2'd2: sel = {v_q[1], v_q[0], v_q[3], v_q[2]};
			2'd3: sel = {v_q[2], v_q[1], v_q[0], v_q[3]};
			default: sel = '0;
		endcase
		for (int j = 0; j < 4; j++) begin
			chain_sum[j] = chain_q[j] + sel[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EN_IDLE;
			chain_q <= CHAIN_IV;
			step_q  <= '0;
			last_q  <= '0;
			bank_q  <= 1'b0;
		end else begin
			unique case (state_q)
				EN_IDLE: begin
					if (ctrl.start) begin
						state_q <= EN_RUN;
						step_q  <= '0;
						last_q  <= ctrl.last_step;
						bank_q  <= ctrl.bank;
					end else if (ctrl.init) begin
						chain_q <= CHAIN_IV;
					end
				end
				EN_RUN: begin
					if (step_q == last_q) begin
						state_q <= EN_ADD;
					end else begin
						step_q <= step_nxt;
					end
				end
				EN_ADD: begin
					chain_q <= chain_sum;
					state_q <= EN_IDLE;
				end
				default: state_q <= EN_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EN_IDLE && ctrl.start) begin
			for (int j = 0; j < 4; j++) begin
				v_q[j] <= chain_q[j];
			end
		end else if (state_q == EN_RUN) begin
			v_q[0] <= v_q[3];
			v_q[1] <= step_new;
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
		end
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == EN_RUN) |-> (step_q <= last_q))
		else $error("step counter ran past the last step");

	a_add_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == EN_ADD) |=> (state_q == EN_IDLE))
		else $error("add-back did not return to idle");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> (state_q == EN_IDLE))
		else $error("compression started while busy");

endmodule
`default_nettype wire

### hdl/md5_round_reduced_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5_round_reduced_hash
// md5 over a byte stream with a programmable number of steps per block
// ----------------------------------------------------------------------------
//
//  channel   direction  payload (low bit first)            transfer when
//  s_*       in         tdata: data_byte; tuser: action     s_tvalid & s_tready
//  m_*       out        tdata: digest words a, b, c, d     m_tvalid & m_tready
//  apb       in/out     step_count at byte address 0       psel & penable & pwrite
//
// message words live in a two-bank ram: the next block loads into one bank
// while the core compresses the other, through the ram's single read port.
// the byte that closes a block waits only while the previous block still
// compresses. a finish writes the marker word, then (15 - word position)
// pad writes, one kick, the compression and the load of the digest; a tail
// of 56 bytes or more adds a turnaround, 16 pad writes, one kick and one
// more compression. reset clears control and chaining state only; the ram
// is not cleared. a stalled output holds its digest while absorb bytes keep
// flowing; only the next finish waits for it.
//
module md5_round_reduced_hash (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [md5rr_pkg::CFG_AW-1:0]     paddr,
	input  logic [md5rr_pkg::CFG_DW-1:0]     pwdata,
	output logic [md5rr_pkg::CFG_DW-1:0]     prdata,
	output logic                             pready,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [md5rr_pkg::BYTE_W-1:0]     s_tdata,   // data_byte
	input  logic                             s_tuser,   // action
	// digest stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [md5rr_pkg::DIGEST_W-1:0]   m_tdata    // digest_word_a, _b, _c, _d
);

	import md5rr_pkg::*;

	typedef enum logic [3:0] {
		ST_ABSORB = 4'b0001,
		ST_PAD    = 4'b0010,
		ST_KICK   = 4'b0100,
		ST_WAIT   = 4'b1000
	} msg_state_t;

	msg_state_t               state_q;
	logic [63:0]              bitcnt_q;
	logic                     bank_q;
	logic [3:0]               wp_q;
	logic                     two_q;
	logic                     out_valid_q;
	logic [DIGEST_W-1:0]      out_data_q;
	logic [STEP_W-1:0]        step_count_q;
	logic [2:0][BYTE_W-1:0]   word_q;

	logic [5:0]               byte_pos;
	logic [1:0]               lane;
	logic [3:0]               widx;
	logic                     is_finish;
	logic                     absorb_xfer;
	logic                     finish_xfer;
	logic                     block_end;
	logic                     fin_load;
	logic [3:0][BYTE_W-1:0]   pad_word;
	logic [5:0]               last_step;
	logic                     cfg_wr;

	logic                     ram_we;
	logic [RAM_AW-1:0]        ram_waddr;
	logic [WORD_W-1:0]        ram_wdata;
	logic [RAM_AW-1:0]        ram_raddr;
	logic [WORD_W-1:0]        ram_rdata;

	core_ctrl_t               core_ctrl;
	logic                     core_busy;
	chain_t                   chain;

	// byte position inside the block comes straight from the bit count
	assign byte_pos  = bitcnt_q[8:3];
	assign lane      = byte_pos[1:0];
	assign widx      = byte_pos[5:2];
	assign is_finish = (s_tuser == ACT_FINISH);

	// a finish needs an idle core and a free output register; the byte that
	// closes a block needs the core free to take that block at once
	always_comb begin
		s_tready = 1'b0;
		if (state_q == ST_ABSORB) begin
			if (is_finish) begin
				s_tready = !core_busy && !out_valid_q;
			end else begin
				s_tready = (byte_pos != LAST_POS) || !core_busy;
			end
		end
	end

	assign absorb_xfer = s_tvalid && s_tready && !is_finish;
	assign finish_xfer = s_tvalid && s_tready && is_finish;
	assign block_end   = absorb_xfer && (byte_pos == LAST_POS);
	assign fin_load    = (state_q == ST_WAIT) && !core_busy && !two_q;

	// zero or out-of-range step count means full md5
	always_comb begin
		if (step_count_q == '0 || step_count_q > MAX_STEPS) begin
			last_step = LAST_STEP_FULL;
		end else begin
			last_step = 6'(step_count_q - 7'd1);
		end
	end

	// word holding the 0x80 marker: earlier bytes of the word, marker, zeros
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (2'(j) < lane) begin
				pad_word[j] = word_q[j];
			end else if (2'(j) == lane) begin
				pad_word[j] = PAD_BYTE;
			end else begin
				pad_word[j] = '0;
			end
		end
		pad_word[3] = (lane == 2'd3) ? PAD_BYTE : '0;
	end

	// ram write side: full words of absorbed bytes, then the padding
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {bank_q, widx};
		ram_wdata = {s_tdata, word_q};
		priority if (absorb_xfer && lane == 2'd3) begin
			ram_we = 1'b1;
		end else if (finish_xfer) begin
			ram_we    = 1'b1;
			ram_wdata = pad_word;
		end else if (state_q == ST_PAD) begin
			ram_we    = 1'b1;
			ram_waddr = {bank_q, wp_q};
			if (!two_q && wp_q == LEN_LO_WORD) begin
				ram_wdata = bitcnt_q[31:0];
			end else if (!two_q && wp_q == LEN_HI_WORD) begin
				ram_wdata = bitcnt_q[63:32];
			end else begin
				ram_wdata = '0;
			end
		end
	end

	assign core_ctrl.start     = block_end || (state_q == ST_KICK);
	assign core_ctrl.init      = fin_load;
	assign core_ctrl.bank      = bank_q;
	assign core_ctrl.last_step = last_step;

	md5rr_ram #(
		.WIDTH (WORD_W),
		.DEPTH (RAM_DEPTH)
	) u_msg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	md5rr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (core_ctrl),
		.ram_rdata (ram_rdata),
		.ram_raddr (ram_raddr),
		.busy      (core_busy),
		.chain     (chain)
	);

	// message sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_ABSORB;
			bitcnt_q <= '0;
			bank_q   <= 1'b0;
			wp_q     <= '0;
			two_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_ABSORB: begin
					if (absorb_xfer) begin
						bitcnt_q <= bitcnt_q + 64'd8;
						if (block_end) begin
							// closed block goes to the core, keep loading the other bank
							bank_q <= ~bank_q;
						end
					end else if (finish_xfer) begin
						two_q   <= (byte_pos >= PAD_SPLIT_POS);
						wp_q    <= widx + 4'd1;
						state_q <= (widx == LAST_WORD) ? ST_KICK : ST_PAD;
					end
				end
				ST_PAD: begin
					if (wp_q == LAST_WORD) begin
						state_q <= ST_KICK;
					end else begin
						wp_q <= wp_q + 4'd1;
					end
				end
				ST_KICK: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (!core_busy) begin
						if (two_q) begin
							// length did not fit: one more block of zeros and length
							two_q   <= 1'b0;
							wp_q    <= '0;
							state_q <= ST_PAD;
						end else begin
							bitcnt_q <= '0;
							state_q  <= ST_ABSORB;
						end
					end
				end
				default: state_q <= ST_ABSORB;
			endcase
		end
	end

	// byte lanes of the word being assembled
	always_ff @(posedge clk) begin
		if (absorb_xfer && lane != 2'd3) begin
			word_q[lane] <= s_tdata;
		end
	end

	// digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_data_q <= chain;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= STEP_COUNT_RESET;
		end else if (cfg_wr && paddr[CFG_AW-1:2] == REG_STEP_COUNT) begin
			step_count_q <= pwdata[STEP_W-1:0];
		end
	end

	always_comb begin
		if (paddr[CFG_AW-1:2] == REG_STEP_COUNT) begin
			prdata = {{(CFG_DW-STEP_W){1'b0}}, step_count_q};
		end else begin
			prdata = '0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |-> !out_valid_q)
		else $error("digest loaded over an untaken result");

	a_pad_idle_core: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD) |-> !core_busy)
		else $error("padding written while the core compresses");

	a_kick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KICK) |=> core_busy)
		else $error("final block did not start compressing");

endmodule
`default_nettype wire

### dv/md5_round_reduced_hash_tb.sv
// ----------------------------------------------------------------------------
// md5_round_reduced_hash_tb
// self-checking bench for the round-reduced md5 byte-stream hash
// ----------------------------------------------------------------------------
//
// a short table of byte and finish transfers runs first at the reset step
// count. The empty-message and "abc" digests are typed in as known md5
// values. The random phases follow. Each phase programs a new step count,
// including 0, 1, 64, 65 and 127, and picks one of four flow patterns. It
// then sends whole messages whose lengths are mostly short or on the padding
// boundaries. Every finish is predicted by a local model of the hash, and
// each digest transfer is checked word by word against the oldest expected
// digest.
//
module md5_round_reduced_hash_tb;
	import md5rr_pkg::*;

	localparam int LIMIT_CYCLES   = 400000;
	localparam int SETTLE_CYCLES  = 200;   // > two compressions plus padding
	localparam int HOLD_CYCLES    = 600;   // long output hold in the pressure phase
	localparam int PHASE_ITEMS    = 50;
	localparam int PHASE_DIGESTS  = 4;
	localparam int NUM_PHASES     = 12;
	localparam int PRESSURE_PHASE = 4;
	localparam int RANDOM_STEPS   = -1;
	localparam logic [CFG_AW-1:0] STEP_ADDR = CFG_AW'(4 * int'(REG_STEP_COUNT));

	// digest as carried on m_tdata, word a in the low bits
	typedef struct packed {
		logic [31:0] word_d;
		logic [31:0] word_c;
		logic [31:0] word_b;
		logic [31:0] word_a;
	} digest_t;

	typedef enum int {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_e;

	typedef struct packed {
		logic       act;
		logic [7:0] data;
		logic       typed;  // digest below is a known value, not a prediction
		digest_t    want;
	} dir_row_t;

	localparam digest_t NO_DIGEST = '0;
	localparam digest_t MD5_EMPTY = {32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4};
	localparam digest_t MD5_ABC   = {32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190};

	localparam int DIR_ROWS = 9;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{ACT_FINISH, 8'h00, 1'b1, MD5_EMPTY},  // empty message right after reset
		'{ACT_ABSORB, 8'h61, 1'b0, NO_DIGEST},
		'{ACT_ABSORB, 8'h62, 1'b0, NO_DIGEST},
		'{ACT_ABSORB, 8'h63, 1'b0, NO_DIGEST},
		'{ACT_FINISH, 8'hFF, 1'b1, MD5_ABC},    // data byte on a finish is ignored
		'{ACT_ABSORB, 8'h00, 1'b0, NO_DIGEST},
		'{ACT_ABSORB, 8'hFF, 1'b0, NO_DIGEST},
		'{ACT_FINISH, 8'h00, 1'b0, NO_DIGEST},
		'{ACT_FINISH, 8'hFF, 1'b1, MD5_EMPTY}   // chain back at its initial value
	};

	localparam int PHASE_STEPS [NUM_PHASES] = '{1, 64, 0, 127, 65, 2, 3, 31, 33, 63, 5,
		RANDOM_STEPS};

	// lengths around the 56 and 64 byte padding boundaries
	localparam int EDGE_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

	localparam logic [31:0] ROUND_K [64] = '{
		32'd3614090360, 32'd3905402710, 32'd606105819,  32'd3250441966,
		32'd4118548399, 32'd1200080426, 32'd2821735955, 32'd4249261313,
		32'd1770035416, 32'd2336552879, 32'd4294925233, 32'd2304563134,
		32'd1804603682, 32'd4254626195, 32'd2792965006, 32'd1236535329,
		32'd4129170786, 32'd3225465664, 32'd643717713,  32'd3921069994,
		32'd3593408605, 32'd38016083,   32'd3634488961, 32'd3889429448,
		32'd568446438,  32'd3275163606, 32'd4107603335, 32'd1163531501,
		32'd2850285829, 32'd4243563512, 32'd1735328473, 32'd2368359562,
		32'd4294588738, 32'd2272392833, 32'd1839030562, 32'd4259657740,
		32'd2763975236, 32'd1272893353, 32'd4139469664, 32'd3200236656,
		32'd681279174,  32'd3936430074, 32'd3572445317, 32'd76029189,
		32'd3654602809, 32'd3873151461, 32'd530742520,  32'd3299628645,
		32'd4096336452, 32'd1126891415, 32'd2878612391, 32'd4237533241,
		32'd1700485571, 32'd2399980690, 32'd4293915773, 32'd2240044497,
		32'd1873313359, 32'd4264355552, 32'd2734768916, 32'd1309151649,
		32'd4149444226, 32'd3174756917, 32'd718787259,  32'd3951481745
	};

	// rotate amounts, four per round
	localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	// dut ports
	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [CFG_AW-1:0]   paddr;
	logic [CFG_DW-1:0]   pwdata;
	logic [CFG_DW-1:0]   prdata;
	logic                pready;
	logic                s_tvalid;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata;   // data_byte
	logic                s_tuser;   // action
	logic                m_tvalid;
	logic                m_tready;
	logic [DIGEST_W-1:0] m_tdata;   // digest_word_a, _b, _c, _d

	// local hash model
	logic [31:0] chain_w [4];
	logic [7:0]  blk_buf [64];
	logic [63:0] msg_bits;
	logic [6:0]  step_cfg;

	// digests still to come, oldest first
	digest_t digest_q [$];

	// flow control and bookkeeping
	int  src_gap_pct;
	int  sink_stall_pct;
	bit  hold_req;
	int  hold_left;
	int  errors;
	int  items_sent;
	int  digests_seen;
	int  cycles;
	digest_t seen_d;
	digest_t due_d;

	md5_round_reduced_hash dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// back to the initial chaining value, length zero
	function automatic void hash_restart();
		chain_w[0] = 32'h67452301;
		chain_w[1] = 32'hefcdab89;
		chain_w[2] = 32'h98badcfe;
		chain_w[3] = 32'h10325476;
		msg_bits   = '0;
	endfunction

	// one block compression with the programmed number of steps
	function automatic void compress_block();
		logic [31:0] mw [16];
		logic [31:0] v [4];
		logic [31:0] x, y, z, f, sum;
		int i, k, n, t, g, r, s;
		for (i = 0; i < 16; i++)
			mw[i] = {blk_buf[4*i+3], blk_buf[4*i+2], blk_buf[4*i+1], blk_buf[4*i]};
		for (k = 0; k < 4; k++)
			v[k] = chain_w[k];
		// zero or anything past 64 means full md5
		n = (step_cfg == 7'd0 || step_cfg > MAX_STEPS) ? 64 : int'(step_cfg);
		for (i = 0; i < n; i++) begin
			// target word walks a, d, c, b
			t = (4 - (i & 3)) & 3;
			x = v[(t + 1) & 3];
			y = v[(t + 2) & 3];
			z = v[(t + 3) & 3];
			r = i >> 4;
			case (r)
				0: begin
					f = (x & y) | (~x & z);
					g = i & 15;
				end
				1: begin
					f = (x & z) | (y & ~z);
					g = (5 * i + 1) & 15;
				end
				2: begin
					f = x ^ y ^ z;
					g = (3 * i + 5) & 15;
				end
				default: begin
					f = y ^ (x | ~z);
					g = (7 * i) & 15;
				end
			endcase
			sum  = v[t] + f + mw[g] + ROUND_K[i];
			s    = ROT_AMT[r * 4 + (i & 3)];
			v[t] = x + ((sum << s) | (sum >> (32 - s)));
		end
		// partial words are added back even on an early stop
		for (k = 0; k < 4; k++)
			chain_w[k] = chain_w[k] + v[k];
	endfunction

	// feed one accepted item, returns 1 with the digest on a finish
	function automatic bit hash_take(input logic act, input logic [7:0] b, output digest_t d);
		int pos, k;
		d   = NO_DIGEST;
		pos = int'(msg_bits[8:3]);
		if (act == ACT_ABSORB) begin
			blk_buf[pos] = b;
			msg_bits     = msg_bits + 64'd8;
			if (pos == int'(LAST_POS))
				compress_block();
			return 1'b0;
		end
		blk_buf[pos] = PAD_BYTE;
		pos++;
		// no room for the length, spill into a second block
		if (pos > int'(PAD_SPLIT_POS)) begin
			while (pos < 64) begin
				blk_buf[pos] = 8'h00;
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < int'(PAD_SPLIT_POS)) begin
			blk_buf[pos] = 8'h00;
			pos++;
		end
		for (k = 0; k < 8; k++)
			blk_buf[int'(PAD_SPLIT_POS) + k] = msg_bits[8*k +: 8];
		compress_block();
		d = {chain_w[3], chain_w[2], chain_w[1], chain_w[0]};
		hash_restart();
		return 1'b1;
	endfunction

	function automatic void check_word(input string tag, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, tag, want, got);
			errors++;
		end
	endfunction

	function automatic void set_flow(input flow_e mode);
		case (mode)
			FLOW_FREE: begin
				src_gap_pct    = 0;
				sink_stall_pct = 0;
			end
			FLOW_SRC_GAPS: begin
				src_gap_pct    = 53;
				sink_stall_pct = 0;
			end
			FLOW_SINK_STALLS: begin
				src_gap_pct    = 0;
				sink_stall_pct = 53;
			end
			default: begin
				src_gap_pct    = 35;
				sink_stall_pct = 35;
			end
		endcase
	endfunction

	// mostly short messages, many on the padding boundaries, some long
	function automatic int pick_len(input bit tiny);
		int r;
		if (tiny)
			return $urandom_range(2);
		r = $urandom_range(99);
		if (r < 45)
			return $urandom_range(8);
		if (r < 80)
			return EDGE_LENS[$urandom_range(9)];
		return $urandom_range(200);
	endfunction

	// one input transfer; valid stays high into the next call unless a gap falls
	task automatic offer(input logic act, input logic [7:0] b, input logic typed,
		input digest_t want);
		digest_t d;
		while (src_gap_pct > 0 && $urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (hash_take(act, b, d))
			digest_q.push_back(typed ? want : d);
	endtask

	task automatic send_message(input int len);
		int j;
		for (j = 0; j < len; j++)
			offer(ACT_ABSORB, 8'($urandom_range(255)), 1'b0, NO_DIGEST);
		offer(ACT_FINISH, 8'($urandom_range(255)), 1'b0, NO_DIGEST);
	endtask

	// setup then access cycle; upper data bits are don't-care
	task automatic write_steps(input logic [6:0] val);
		logic [CFG_DW-1:0] junk;
		junk    = $urandom();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= STEP_ADDR;
		pwdata  <= {junk[CFG_DW-1:STEP_W], val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		step_cfg = val;
	endtask

	// all digests in, then room for any compression still running
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver ready, with the long hold counted here
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// digest transfers against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_d = m_tdata;
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest transfer, expected none actual %h",
					$time, m_tdata);
				errors++;
			end else begin
				due_d = digest_q.pop_front();
				check_word("digest_word_a", due_d.word_a, seen_d.word_a);
				check_word("digest_word_b", due_d.word_b, seen_d.word_b);
				check_word("digest_word_c", due_d.word_c, seen_d.word_c);
				check_word("digest_word_d", due_d.word_d, seen_d.word_d);
			end
			digests_seen++;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d digests pending", cycles, digest_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int p, start_items, phase_msgs;
		logic [6:0] steps;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = ACT_ABSORB;
		m_tready       = 1'b0;
		hold_req       = 1'b0;
		hold_left      = 0;
		errors         = 0;
		items_sent     = 0;
		digests_seen   = 0;
		cycles         = 0;
		step_cfg       = STEP_COUNT_RESET;
		hash_restart();
		set_flow(FLOW_FREE);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at the reset step count
		for (p = 0; p < DIR_ROWS; p++)
			offer(DIR_TABLE[p].act, DIR_TABLE[p].data, DIR_TABLE[p].typed, DIR_TABLE[p].want);
		wait_quiet();

		// random phases, each with its own step count and flow pattern
		for (p = 0; p < NUM_PHASES; p++) begin
			if (PHASE_STEPS[p] == RANDOM_STEPS)
				steps = 7'($urandom_range(127));
			else
				steps = 7'(PHASE_STEPS[p]);
			write_steps(steps);
			set_flow(flow_e'(p % 4));
			// tiny messages pile up finishes behind the held output
			if (p == PRESSURE_PHASE)
				hold_req = 1'b1;
			start_items = items_sent;
			phase_msgs  = 0;
			while (items_sent - start_items < PHASE_ITEMS || phase_msgs < PHASE_DIGESTS) begin
				send_message(pick_len(p == PRESSURE_PHASE));
				phase_msgs++;
			end
			wait_quiet();
		end

		$display("%0d input transfers over %0d step-count phases, %0d digests checked",
			items_sent, NUM_PHASES + 1, digests_seen);
		$display("step counts from 0 to 127, padding-boundary lengths, gaps, stalls, long hold");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
hdl/md5rr_pkg.sv
hdl/md5rr_ram.sv
hdl/md5rr_core.sv
hdl/md5_round_reduced_hash.sv
dv/md5_round_reduced_hash_tb.sv
